// File: hw/rtl/lsbp_pkg.sv
// shared types, constants and helper functions of the laser scan bitmap plotter
`timescale 1ns / 1ps

package lsbp_pkg;

   // bitmap geometry and scan length
   localparam int ROWS        = 240;
   localparam int COLS        = 320;
   localparam int MAX_SAMPLES = 4096;

   // field widths
   localparam int ROW_W      = 8;
   localparam int COL_W      = 9;
   localparam int PIX_W      = 8;
   localparam int SCALE_W    = 8;
   localparam int ANGLE_W    = 16;
   localparam int STEP_W     = 12;
   localparam int RANGE_W    = 16;
   localparam int IDX_W      = $clog2(MAX_SAMPLES);
   localparam int ANG_PROD_W = IDX_W + STEP_W;

   // stream payload widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - ROW_W - COL_W - PIX_W;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PLOT_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ANGLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP  = 2'd2;
   localparam logic [SCALE_W-1:0] PLOT_SCALE_RST  = 8'd40;
   localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'hC000;
   localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 12'd64;

   // item kinds
   localparam logic FUNC_PLOT = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // bitmap centers: row is offset by half the columns, col by half the rows
   localparam int ROW_CENTER = COLS / 2;
   localparam int COL_CENTER = ROWS / 2;

   // cordic
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int CORDIC_W     = 18;
   localparam int CORDIC_X0    = 19898;
   localparam int SC_W         = 16;
   localparam int SAT_LIM      = 32767;

   // scaling product, q23 fraction
   localparam int MAG_W      = SCALE_W + RANGE_W;
   localparam int PROD_W     = MAG_W + 1 + SC_W;
   localparam int FRAC_BITS  = 23;
   localparam int TRUNC_BIAS = 2 ** FRAC_BITS - 1;
   localparam int COORD_W    = 18;

   // bitmap memory, 32 pixels per word
   localparam int BIT_W   = $clog2(ROWS * COLS);
   localparam int WORD_W  = 32;
   localparam int SEL_W   = $clog2(WORD_W);
   localparam int WORDS   = (ROWS * COLS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W = $clog2(WORDS);

   localparam logic [PIX_W-1:0] PIXEL_SET = 8'hFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ANGLE,
      ST_INIT,
      ST_ROTATE,
      ST_SCALE,
      ST_MUL_COS,
      ST_MUL_SIN,
      ST_COL,
      ST_ADDR,
      ST_MEM_RD,
      ST_MEM_WR,
      ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic take;
      logic clear_step;
      logic angle_mul;
      logic cordic_init;
      logic cordic_step;
      logic scale;
      logic mul_cos;
      logic mul_sin;
      logic col_calc;
      logic addr_calc;
      logic mem_rd;
      logic mem_wr;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic cordic_last;
      logic func_read;
      logic on_map;
      logic out_free;
   } sts_type;

   // arctangent of 2^-i in units of pi/32768, rounded
   function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
      logic signed [CORDIC_W-1:0] v;
      case (i)
         4'd0:    v = CORDIC_W'(8192);
         4'd1:    v = CORDIC_W'(4836);
         4'd2:    v = CORDIC_W'(2555);
         4'd3:    v = CORDIC_W'(1297);
         4'd4:    v = CORDIC_W'(651);
         4'd5:    v = CORDIC_W'(326);
         4'd6:    v = CORDIC_W'(163);
         4'd7:    v = CORDIC_W'(81);
         4'd8:    v = CORDIC_W'(41);
         4'd9:    v = CORDIC_W'(20);
         4'd10:   v = CORDIC_W'(10);
         4'd11:   v = CORDIC_W'(5);
         4'd12:   v = CORDIC_W'(3);
         4'd13:   v = CORDIC_W'(1);
         4'd14:   v = CORDIC_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // clamp a cordic output to +-32767
   function automatic logic signed [SC_W-1:0] sat_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] hi;
      logic signed [CORDIC_W-1:0] lo;
      logic signed [SC_W-1:0]     r;
      hi = CORDIC_W'(SAT_LIM);
      lo = -hi;
      if (v > hi) begin
         r = SC_W'(SAT_LIM);
      end else if (v < lo) begin
         r = -SC_W'(SAT_LIM);
      end else begin
         r = v[SC_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/lsbp_ctrl.sv
// sequencing state machine of the laser scan bitmap plotter
`timescale 1ns / 1ps

module lsbp_ctrl import lsbp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = sts.func_read ? ST_ADDR : ST_ANGLE;
         end
         ST_ANGLE: begin
            cmd.angle_mul = 1'b1;
            state_in      = ST_INIT;
         end
         ST_INIT: begin
            cmd.cordic_init = 1'b1;
            state_in        = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.cordic_step = 1'b1;
            if (sts.cordic_last) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MUL_COS;
         end
         ST_MUL_COS: begin
            cmd.mul_cos = 1'b1;
            state_in    = ST_MUL_SIN;
         end
         ST_MUL_SIN: begin
            cmd.mul_sin = 1'b1;
            state_in    = ST_COL;
         end
         ST_COL: begin
            cmd.col_calc = 1'b1;
            state_in     = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = ST_MEM_RD;
         end
         ST_MEM_RD: begin
            // pixels off the bitmap skip the memory
            if (sts.on_map) begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_MEM_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MEM_WR: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/lsbp_dpath.sv
// datapath of the laser scan bitmap plotter: registers, cordic, scaling and bitmap memory
`timescale 1ns / 1ps

module lsbp_dpath import lsbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_func,
   input  logic                  req_first,
   input  logic [RANGE_W-1:0]    req_range,
   input  logic [ROW_W-1:0]      req_row,
   input  logic [COL_W-1:0]      req_col,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_plotted,
   output logic [ROW_W-1:0]      rsp_row,
   output logic [COL_W-1:0]      rsp_col,
   output logic [PIX_W-1:0]      rsp_pixel
);

   // control registers
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [ANGLE_W-1:0] start_ff, start_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [WADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                       func_ff, func_in;
   logic [RANGE_W-1:0]         range_ff, range_in;
   logic [ROW_W-1:0]           rrow_ff, rrow_in;
   logic [COL_W-1:0]           rcol_ff, rcol_in;
   logic [ANG_PROD_W-1:0]      ang_prod_ff, ang_prod_in;
   logic                       neg_ff, neg_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic signed [SC_W-1:0]     cos_ff, cos_in;
   logic signed [SC_W-1:0]     sin_ff, sin_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [COORD_W-1:0]  row_ff, row_in;
   logic signed [COORD_W-1:0]  col_ff, col_in;
   logic                       on_map_ff, on_map_in;
   logic [WADDR_W-1:0]         word_addr_ff, word_addr_in;
   logic [SEL_W-1:0]           sel_ff, sel_in;
   logic [ROW_W-1:0]           row_idx_ff, row_idx_in;
   logic [COL_W-1:0]           col_idx_ff, col_idx_in;
   logic [WORD_W-1:0]          rd_word_ff;
   logic                       pix_bit_ff, pix_bit_in;
   logic                       rsp_plotted_ff, rsp_plotted_in;
   logic [ROW_W-1:0]           rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]           rsp_col_ff, rsp_col_in;
   logic [PIX_W-1:0]           rsp_pixel_ff, rsp_pixel_in;

   // combinational helpers
   logic [ANGLE_W-1:0]         angle_v;
   logic                       fold_neg;
   logic [ANGLE_W-1:0]         folded;
   logic signed [CORDIC_W-1:0] dx, dy, atan_v;
   logic signed [SC_W-1:0]     x_sat, y_sat;
   logic signed [SC_W-1:0]     mul_op;
   logic signed [PROD_W-1:0]   biased, shifted;
   logic signed [COORD_W-1:0]  trunc_v;
   logic [ROW_W-1:0]           row_sel;
   logic [COL_W-1:0]           col_sel;
   logic [BIT_W-1:0]           bit_v;
   logic [WORD_W-1:0]          mask;
   logic                       mem_we;
   logic [WADDR_W-1:0]         mem_waddr;
   logic [WORD_W-1:0]          mem_wdata;
   logic                       plotted_v;

   logic [WORD_W-1:0] bitmap_mem [WORDS];

   // angle, fold into [-pi/2, pi/2) and cordic micro-rotation
   always_comb begin
      angle_v  = start_ff + ang_prod_ff[ANGLE_W-1:0];
      fold_neg = angle_v[ANGLE_W-1] ^ angle_v[ANGLE_W-2];
      folded   = angle_v ^ {fold_neg, {(ANGLE_W-1){1'b0}}};
      dx       = y_ff >>> iter_ff;
      dy       = x_ff >>> iter_ff;
      atan_v   = atan_lut(iter_ff);
      x_sat    = sat_q15(x_ff);
      y_sat    = sat_q15(y_ff);
      mul_op   = cmd.mul_sin ? sin_ff : cos_ff;
   end

   // truncate q23 product toward zero
   always_comb begin
      biased  = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(TRUNC_BIAS) : PROD_W'(0));
      shifted = biased >>> FRAC_BITS;
      trunc_v = shifted[COORD_W-1:0];
   end

   // pixel select and bit address
   always_comb begin
      if (func_ff == FUNC_READ) begin
         row_sel   = rrow_ff;
         col_sel   = rcol_ff;
         on_map_in = (32'(rrow_ff) < 32'(ROWS)) && (32'(rcol_ff) < 32'(COLS));
      end else begin
         row_sel   = row_ff[ROW_W-1:0];
         col_sel   = col_ff[COL_W-1:0];
         on_map_in = (row_ff > COORD_W'(0)) && (row_ff < COORD_W'(ROWS))
                  && (col_ff > COORD_W'(0)) && (col_ff < COORD_W'(COLS));
      end
      bit_v        = BIT_W'(row_sel) * BIT_W'(COLS) + BIT_W'(col_sel);
      word_addr_in = WADDR_W'(bit_v >> SEL_W);
      sel_in       = bit_v[SEL_W-1:0];
      row_idx_in   = row_sel;
      col_idx_in   = col_sel;
   end

   // memory write port: clearing pass or read-modify-write
   always_comb begin
      mask      = WORD_W'(1) << sel_ff;
      mem_we    = cmd.clear_step || cmd.mem_wr;
      mem_waddr = cmd.clear_step ? clr_addr_ff : word_addr_ff;
      if (cmd.clear_step) begin
         mem_wdata = '0;
      end else if (func_ff == FUNC_READ) begin
         mem_wdata = rd_word_ff & ~mask;
      end else begin
         mem_wdata = rd_word_ff | mask;
      end
      pix_bit_in = rd_word_ff[sel_ff];
   end

   // next values of the sequencing registers
   always_comb begin
      scale_in     = scale_ff;
      start_in     = start_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      clr_addr_in  = clr_addr_ff;
      func_in      = func_ff;
      range_in     = range_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      ang_prod_in  = ang_prod_ff;
      neg_in       = neg_ff;
      iter_in      = iter_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      mag_in       = mag_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      prod_in      = prod_ff;
      row_in       = row_ff;
      col_in       = col_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_PLOT_SCALE:  scale_in = csr_data[SCALE_W-1:0];
            CSR_START_ANGLE: start_in = csr_data[ANGLE_W-1:0];
            CSR_ANGLE_STEP:  step_in  = csr_data[STEP_W-1:0];
            default:         ;
         endcase
      end

      if (cmd.clear_step) clr_addr_in = clr_addr_ff + WADDR_W'(1);

      // item transfer in
      if (cmd.take) begin
         func_in  = req_func;
         range_in = req_range;
         rrow_in  = req_row;
         rcol_in  = req_col;
         if (req_func == FUNC_PLOT && req_first) idx_in = '0;
      end

      // sample angle offset, then advance the sample index
      if (cmd.angle_mul) begin
         ang_prod_in = ANG_PROD_W'(idx_ff) * ANG_PROD_W'(step_ff);
         idx_in      = (idx_ff == IDX_W'(MAX_SAMPLES - 1)) ? '0 : idx_ff + IDX_W'(1);
      end

      if (cmd.cordic_init) begin
         neg_in  = fold_neg;
         iter_in = '0;
         x_in    = CORDIC_W'(CORDIC_X0);
         y_in    = '0;
         z_in    = {{(CORDIC_W-ANGLE_W){folded[ANGLE_W-1]}}, folded};
      end

      if (cmd.cordic_step) begin
         iter_in = iter_ff + ITER_W'(1);
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
      end

      // saturate, undo the fold, form scale times range
      if (cmd.scale) begin
         mag_in = MAG_W'(scale_ff) * MAG_W'(range_ff);
         cos_in = neg_ff ? -x_sat : x_sat;
         sin_in = neg_ff ? -y_sat : y_sat;
      end

      // one shared multiplier, cosine then sine
      if (cmd.mul_cos || cmd.mul_sin) begin
         prod_in = $signed({1'b0, mag_ff}) * mul_op;
      end
      if (cmd.mul_sin) row_in = COORD_W'(ROW_CENTER) - trunc_v;
      if (cmd.col_calc) col_in = COORD_W'(COL_CENTER) - trunc_v;
   end

   // result register
   always_comb begin
      plotted_v      = (func_ff == FUNC_PLOT) && on_map_ff;
      rsp_plotted_in = plotted_v;
      rsp_row_in     = plotted_v ? row_idx_ff : '0;
      rsp_col_in     = plotted_v ? col_idx_ff : '0;
      rsp_pixel_in   = ((func_ff == FUNC_READ) && on_map_ff && pix_bit_ff) ? PIXEL_SET : '0;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= PLOT_SCALE_RST;
         start_ff     <= START_ANGLE_RST;
         step_ff      <= ANGLE_STEP_RST;
         idx_ff       <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         start_ff     <= start_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      range_ff    <= range_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      ang_prod_ff <= ang_prod_in;
      neg_ff      <= neg_in;
      iter_ff     <= iter_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      mag_ff      <= mag_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      prod_ff     <= prod_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      if (cmd.addr_calc) begin
         on_map_ff    <= on_map_in;
         word_addr_ff <= word_addr_in;
         sel_ff       <= sel_in;
         row_idx_ff   <= row_idx_in;
         col_idx_ff   <= col_idx_in;
      end
      if (cmd.mem_wr) pix_bit_ff <= pix_bit_in;
      if (cmd.load_rsp) begin
         rsp_plotted_ff <= rsp_plotted_in;
         rsp_row_ff     <= rsp_row_in;
         rsp_col_ff     <= rsp_col_in;
         rsp_pixel_ff   <= rsp_pixel_in;
      end
   end

   // bitmap memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) bitmap_mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_rd) rd_word_ff <= bitmap_mem[word_addr_ff];
   end

   // status
   always_comb begin
      sts.clear_last  = (clr_addr_ff == WADDR_W'(WORDS - 1));
      sts.cordic_last = (iter_ff == ITER_W'(CORDIC_STEPS - 1));
      sts.func_read   = (func_ff == FUNC_READ);
      sts.on_map      = on_map_ff;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_plotted = rsp_plotted_ff;
   assign rsp_row     = rsp_row_ff;
   assign rsp_col     = rsp_col_ff;
   assign rsp_pixel   = rsp_pixel_ff;

endmodule

// File: hw/rtl/laser_scan_bitmap_plotter_unit.sv
// top level of the laser scan bitmap plotter: stream ports, controller and datapath
`timescale 1ns / 1ps

// Plots laser range samples into a 240 x 320 hit bitmap and reads pixels back.
// A plot item takes the sample angle start_angle + index * angle_step, runs a
// 16-step CORDIC one step per cycle, scales range by plot_scale on one shared
// multiplier and sets the pixel by read-modify-write of a 32-bit word memory;
// an item whose pixel falls off the bitmap skips the memory. A read item returns
// the pixel as 255 or 0 and clears it. One item is in work at a time; a finished
// result waits in an output register while the next item is taken. After reset
// a clearing pass writes the 2400 memory words, one per cycle, before the first
// item is accepted; register writes are taken at once.

module laser_scan_bitmap_plotter_unit import lsbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // range_q8[15:0], read_row[23:16], read_col[32:24]
   input  logic [REQ_USER_W-1:0] req_tuser,  // func[0], first_of_scan[1]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // plot_row[7:0], plot_col[16:8], pixel_value[24:17]
   output logic                  rsp_tuser,  // plotted
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type          cmd;
   sts_type          sts;
   logic [ROW_W-1:0] rsp_row;
   logic [COL_W-1:0] rsp_col;
   logic [PIX_W-1:0] rsp_pixel;

   // registers accept a write every cycle
   assign csr_ready = 1'b1;

   lsbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lsbp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_func    (req_tuser[0]),
      .req_first   (req_tuser[1]),
      .req_range   (req_tdata[RANGE_W-1:0]),
      .req_row     (req_tdata[RANGE_W +: ROW_W]),
      .req_col     (req_tdata[RANGE_W+ROW_W +: COL_W]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_plotted (rsp_tuser),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_pixel   (rsp_pixel)
   );

   // result packing, lowest field first
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_pixel, rsp_col, rsp_row};

endmodule

// File: tb/tb_laser_scan_bitmap_plotter_unit.sv
// self-checking testbench of the laser scan bitmap plotter: directed table, then random phases
`timescale 1ns / 1ps

module tb_laser_scan_bitmap_plotter_unit;
   import lsbp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 300;
   localparam int ATAN_PI [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                   41, 20, 10, 5, 3, 1, 1, 0};

   typedef struct packed {
      logic             plotted;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } pixel_result_type;

   typedef struct packed {
      logic               typed;
      logic               func;
      logic [RANGE_W-1:0] range_q8;
      logic               first;
      logic [ROW_W-1:0]   rrow;
      logic [COL_W-1:0]   rcol;
      pixel_result_type   want;
   } scan_item_type;

   localparam pixel_result_type NO_RESULT   = '0;
   localparam pixel_result_type CENTER_HIT  = '{1'b1, 8'd160, 9'd120, 8'd0};
   localparam pixel_result_type CENTER_READ = '{1'b0, 8'd0, 9'd0, PIXEL_SET};

   // directed items: typed answers where they are obvious, the rest predicted
   localparam int DIRECTED_N = 18;
   localparam scan_item_type DIRECTED_TAB [DIRECTED_N] = '{
      // reads right after reset find a clear bitmap
      '{1'b1, FUNC_READ, 16'h0000, 1'b0, 8'd0,   9'd0,   NO_RESULT},
      '{1'b1, FUNC_READ, 16'hFFFF, 1'b1, 8'd239, 9'd319, NO_RESULT},
      // reads outside the bitmap
      '{1'b1, FUNC_READ, 16'h0000, 1'b0, 8'd255, 9'd511, NO_RESULT},
      '{1'b1, FUNC_READ, 16'h0000, 1'b0, 8'd240, 9'd0,   NO_RESULT},
      '{1'b1, FUNC_READ, 16'h0000, 1'b0, 8'd0,   9'd320, NO_RESULT},
      // zero range lands on the center, twice for a repeated hit
      '{1'b1, FUNC_PLOT, 16'h0000, 1'b1, 8'd0,   9'd0,   CENTER_HIT},
      '{1'b1, FUNC_PLOT, 16'h0000, 1'b0, 8'd255, 9'd511, CENTER_HIT},
      // read returns the set pixel, then finds it cleared
      '{1'b1, FUNC_READ, 16'h0000, 1'b0, 8'd160, 9'd120, CENTER_READ},
      '{1'b1, FUNC_READ, 16'hFFFF, 1'b1, 8'd160, 9'd120, NO_RESULT},
      // largest range falls off the bitmap
      '{1'b1, FUNC_PLOT, 16'hFFFF, 1'b1, 8'd0,   9'd0,   NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h0100, 1'b0, 8'd0,   9'd0,   NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h0400, 1'b0, 8'd17,  9'd300, NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h0001, 1'b0, 8'd0,   9'd0,   NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h0300, 1'b1, 8'd0,   9'd0,   NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h0380, 1'b0, 8'd0,   9'd0,   NO_RESULT},
      '{1'b0, FUNC_READ, 16'h0000, 1'b0, 8'd160, 9'd240, NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h8000, 1'b0, 8'd255, 9'd511, NO_RESULT},
      '{1'b0, FUNC_PLOT, 16'h00FF, 1'b0, 8'd0,   9'd0,   NO_RESULT}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the block: registers, scan position and bitmap
   logic [SCALE_W-1:0] cfg_scale = PLOT_SCALE_RST;
   logic [ANGLE_W-1:0] cfg_start = START_ANGLE_RST;
   logic [STEP_W-1:0]  cfg_step  = ANGLE_STEP_RST;
   logic [IDX_W-1:0]   scan_pos  = '0;
   bit                 hit_map [ROWS][COLS];
   logic [16:0]        lit_pixels [$];  // {row, col} of recent hits

   pixel_result_type answers_due [$];
   int               fail_count = 0;

   // idling control shared by the stimulus and the receiver
   bit req_idle_on  = 1'b0;
   bit rsp_idle_on  = 1'b0;
   int hold_req_cnt = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int stall_left   = 0;
   int cycles;

   laser_scan_bitmap_plotter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // q23 product truncated toward zero
   function automatic longint drop_q23(input longint p);
      if (p >= 0) begin
         return p >>> 23;
      end
      return -((-p) >>> 23);
   endfunction

   // plot or read one item against the shadow state
   function automatic pixel_result_type bitmap_answer(input scan_item_type it);
      pixel_result_type   res;
      logic [ANGLE_W-1:0] ang;
      logic [ANGLE_W-1:0] fold;
      logic               flip;
      int                 x, y, z, dx, dy, i;
      longint             mag, prow, pcol;
      res = '0;
      if (it.func == FUNC_PLOT) begin
         if (it.first) begin
            scan_pos = '0;
         end
         ang = cfg_start + scan_pos * cfg_step;
         // fold the second and third quadrants by half a turn
         flip = (ang[15:14] == 2'b01) || (ang[15:14] == 2'b10);
         fold = flip ? (ang ^ 16'h8000) : ang;
         x = CORDIC_X0;
         y = 0;
         z = int'($signed(fold));
         for (i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_PI[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_PI[i];
            end
         end
         if (x > 32767) x = 32767;
         if (x < -32767) x = -32767;
         if (y > 32767) y = 32767;
         if (y < -32767) y = -32767;
         if (flip) begin
            x = -x;
            y = -y;
         end
         mag  = longint'(cfg_scale) * longint'(it.range_q8);
         prow = ROW_CENTER - drop_q23(mag * x);
         pcol = COL_CENTER - drop_q23(mag * y);
         if (prow > 0 && prow < ROWS && pcol > 0 && pcol < COLS) begin
            hit_map[prow][pcol] = 1'b1;
            res.plotted = 1'b1;
            res.row     = prow[ROW_W-1:0];
            res.col     = pcol[COL_W-1:0];
            lit_pixels.insert(lit_pixels.size(), {res.row, res.col});
            if (lit_pixels.size() > 64) begin
               void'(lit_pixels.pop_front());
            end
         end
         scan_pos = scan_pos + 1'b1;
      end else if (it.rrow < ROWS && it.rcol < COLS) begin
         if (hit_map[it.rrow][it.rcol]) begin
            res.pixel = PIXEL_SET;
         end
         hit_map[it.rrow][it.rcol] = 1'b0;
      end
      return res;
   endfunction

   // random item: mostly ranges bounded by the scale, reads often aimed at recent hits
   function automatic scan_item_type random_item(input int plot_pct, input int restart_odds);
      scan_item_type s;
      int            span, pick;
      logic [16:0]   spot;
      s = '0;
      s.range_q8 = RANGE_W'($urandom);
      s.first    = 1'($urandom);
      s.rrow     = ROW_W'($urandom);
      s.rcol     = COL_W'($urandom);
      if ($urandom_range(0, 99) < plot_pct) begin
         s.func  = FUNC_PLOT;
         s.first = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
         if ($urandom_range(0, 9) != 0) begin
            span = (cfg_scale == 0) ? 65535 : (200 * 256) / int'(cfg_scale);
            s.range_q8 = RANGE_W'($urandom_range(0, span));
         end
      end else begin
         s.func = FUNC_READ;
         pick   = $urandom_range(0, 99);
         if (pick < 50 && lit_pixels.size() > 0) begin
            spot   = lit_pixels[$urandom_range(0, lit_pixels.size() - 1)];
            s.rrow = spot[16:9];
            s.rcol = spot[8:0];
         end else if (pick < 85) begin
            s.rrow = ROW_W'($urandom_range(0, ROWS - 1));
            s.rcol = COL_W'($urandom_range(0, COLS - 1));
         end
      end
      return s;
   endfunction

   // offer one item, predict it at the transfer; valid stays high afterwards
   task automatic offer_item(input scan_item_type it);
      int               gap;
      pixel_result_type guess;
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, it.rcol, it.rrow, it.range_q8};
      req_tuser  <= {it.first, it.func};
      do @(posedge clock); while (!req_tready);
      guess = bitmap_answer(it);
      answers_due.insert(answers_due.size(), it.typed ? it.want : guess);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // one register transfer; csr_valid is lowered by the caller
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PLOT_SCALE:  cfg_scale = val[SCALE_W-1:0];
         CSR_START_ANGLE: cfg_start = val;
         CSR_ANGLE_STEP:  cfg_step  = val[STEP_W-1:0];
         default:         ;
      endcase
   endtask

   task automatic program_regs(input logic [7:0] scale, input logic [15:0] start,
                               input logic [11:0] step);
      write_reg(CSR_PLOT_SCALE, {8'b0, scale});
      write_reg(CSR_START_ANGLE, start);
      write_reg(CSR_ANGLE_STEP, {4'b0, step});
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall after each transfer, long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            stall_left = rsp_idle_on ? $urandom_range(0, 4) : 0;
         end
         if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[16:8], rsp_tdata[24:17]};
         if (answers_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected result: plotted %0d row %0d col %0d pixel %0d",
                        got.plotted, got.row, got.col, got.pixel);
            end
         end else begin
            want = answers_due.pop_front();
            if (got.plotted !== want.plotted || got.row !== want.row ||
                got.col !== want.col || got.pixel !== want.pixel) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: expected plotted %0d row %0d col %0d pixel %0d, ",
                           want.plotted, want.row, want.col, want.pixel,
                           "got plotted %0d row %0d col %0d pixel %0d",
                           got.plotted, got.row, got.col, got.pixel);
               end
            end
         end
      end
   end

   // run limit
   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus
   initial begin
      int phase, k, count, pct, odds;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset settings, no idling
      for (k = 0; k < DIRECTED_N; k++) begin
         offer_item(DIRECTED_TAB[k]);
      end

      for (phase = 0; phase < 10; phase++) begin
         // sender pauses until every result is back before touching registers
         drain_results();
         count = 140;
         pct   = 65;
         odds  = 40;
         case (phase)
            0: ;
            1: program_regs(8'd255, 16'h7FFF, 12'd4095);
            2: program_regs(8'd0, 16'h8000, 12'd0);
            3: program_regs(8'd1, 16'h0000, 12'd1);
            5: program_regs(PLOT_SCALE_RST, START_ANGLE_RST, ANGLE_STEP_RST);
            6: program_regs(8'd255, 16'($urandom), 12'($urandom));
            7: begin
               // longer scan without restarts so the angle sweeps far around
               program_regs(8'($urandom_range(8, 60)), 16'($urandom),
                            12'($urandom_range(1, 4095)));
               count = 220;
               pct   = 97;
               odds  = 0;
            end
            default: program_regs(8'($urandom), 16'($urandom), 12'($urandom));
         endcase
         req_idle_on = (phase % 4 != 0);
         rsp_idle_on = (phase % 4 != 0) && (phase % 4 != 3);
         if (phase == 5) begin
            // receiver holds off while the sender keeps offering
            hold_req_cnt <= hold_req_cnt + 1;
         end
         for (k = 0; k < count; k++) begin
            offer_item(random_item(pct, odds));
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
